// ===== sv/cpfa_pkg.sv =====
// ----------------------------------------------------------------------------
// cpfa_pkg: shared types and codes for the copy-on-write frame allocator
// Word formats of the command and result channels, the internal memory
// port structs and the opcode, rights and status codes.
// ----------------------------------------------------------------------------
package cpfa_pkg;

    // opcodes
    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_FAULT = 2'd2;
    localparam logic [1:0] OP_SHARE = 2'd3;

    // access rights codes and bits
    localparam logic [1:0] RIGHTS_RO   = 2'b01;
    localparam logic [1:0] RIGHTS_RW   = 2'b11;
    localparam int         RIGHT_WRITE = 1;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOFRAME  = 3'd1;
    localparam logic [2:0] ST_INVALID  = 3'd2;
    localparam logic [2:0] ST_READONLY = 3'd3;
    localparam logic [2:0] ST_NOTCOW   = 3'd4;

    localparam logic [7:0] COUNT_MAX = 8'hFF;

    // command word
    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] page_number;
        logic [1:0] access_rights;
    } cmd_t;

    // result word
    typedef struct packed {
        logic [2:0] status;
        logic [3:0] frame_number;
    } result_t;

    // one page entry
    typedef struct packed {
        logic       valid;
        logic       writable;
        logic       origin_ro;
        logic [3:0] frame;
    } entry_t;

    // entry memory write port
    typedef struct packed {
        logic       en;
        logic [7:0] addr;
        entry_t     data;
    } entry_wr_t;

    // count memory write port
    typedef struct packed {
        logic       en;
        logic [3:0] frame;
        logic [7:0] count;
    } cnt_wr_t;

    // count memory read result and free-frame search
    typedef struct packed {
        logic [7:0] count;
        logic       any_free;
        logic [3:0] free_frame;
    } cnt_rd_t;

endpackage

// ===== sv/cow_page_frame_allocator_core.sv =====
// ----------------------------------------------------------------------------
// cow_page_frame_allocator_core: copy-on-write page frame allocator
// The result strobe is registered: an accepted word passes the count and exec
// states (and a copy state for a fault that copies to a fresh frame); a new word
// is taken only back in idle, after the entry read, the count read and the write back.
// Reset: all entries invalid and all frames free at once, no clearing pass.
// Results are strobed for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module cow_page_frame_allocator_core
    import cpfa_pkg::*;
#(
    parameter int FRAMES            = 16,
    parameter int ENTRIES_PER_TABLE = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  cmd_t    cmd,
    output logic    done,
    output result_t result
);

    localparam int         FRAMES_USED = (FRAMES < 16) ? FRAMES : 16;
    localparam int         PAGES_USED  = ENTRIES_PER_TABLE * ENTRIES_PER_TABLE;
    localparam int         PAGE_DEPTH  = (PAGES_USED < 256) ? PAGES_USED : 256;
    localparam logic [12:0] PAGE_LIMIT = 13'(PAGES_USED);

    typedef enum logic [1:0] {S_IDLE, S_COUNT, S_EXEC, S_COPY} state_t;

    state_t    state_reg;
    cmd_t      cmd_reg;
    logic      in_range_reg;
    logic      done_reg;
    result_t   result_reg;

    logic      accept;
    entry_t    ent_rd;
    entry_wr_t ent_wr;
    cnt_rd_t   cnt_rd;
    cnt_wr_t   cnt_wr;
    cnt_wr_t   exec_cnt_wr;
    result_t   result_next;
    logic      copy_next;
    logic [7:0] cnt;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // page entry store
    cpfa_entry_mem #(
        .PAGE_DEPTH (PAGE_DEPTH)
    ) u_entry_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (cmd.page_number),
        .rd_data (ent_rd),
        .wr      (ent_wr)
    );

    // frame reference counts
    cpfa_count_mem #(
        .FRAMES_USED (FRAMES_USED)
    ) u_count_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (state_reg == S_COUNT),
        .rd_frame (ent_rd.frame),
        .rd_data  (cnt_rd),
        .wr       (cnt_wr)
    );

    assign cnt = cnt_rd.count;

    // operation decode and write back
    always_comb
    begin
        ent_wr      = '0;
        ent_wr.addr = cmd_reg.page_number;
        ent_wr.data = ent_rd;
        exec_cnt_wr = '0;
        result_next = '0;
        copy_next   = 1'b0;
        priority if (!in_range_reg)
        begin
            result_next.status = ST_INVALID;
        end
        else if (cmd_reg.opcode == OP_ALLOC)
        begin
            if (!cnt_rd.any_free)
            begin
                result_next.status = ST_NOFRAME;
            end
            else
            begin
                ent_wr.en         = 1'b1;
                ent_wr.data.valid = 1'b1;
                ent_wr.data.frame = cnt_rd.free_frame;
                if (cmd_reg.access_rights == RIGHTS_RO)
                begin
                    ent_wr.data.writable  = 1'b0;
                    ent_wr.data.origin_ro = 1'b1;
                end
                else if (cmd_reg.access_rights == RIGHTS_RW)
                begin
                    ent_wr.data.writable  = 1'b1;
                    ent_wr.data.origin_ro = 1'b0;
                end
                exec_cnt_wr.en           = 1'b1;
                exec_cnt_wr.frame        = cnt_rd.free_frame;
                exec_cnt_wr.count        = 8'd1;
                result_next.frame_number = cnt_rd.free_frame;
            end
        end
        else if (!ent_rd.valid)
        begin
            result_next.status = ST_INVALID;
        end
        else if (cmd_reg.opcode == OP_FREE)
        begin
            ent_wr.en         = 1'b1;
            ent_wr.data       = '0;
            exec_cnt_wr.en    = 1'b1;
            exec_cnt_wr.frame = ent_rd.frame;
            exec_cnt_wr.count = (cnt == 8'd0) ? 8'd0 : cnt - 8'd1;
        end
        else if (cmd_reg.opcode == OP_FAULT)
        begin
            if (ent_rd.writable || !cmd_reg.access_rights[RIGHT_WRITE])
            begin
                result_next.status = ST_NOTCOW;
            end
            else if (ent_rd.origin_ro)
            begin
                result_next.status = ST_READONLY;
            end
            else if (cnt <= 8'd1)
            begin
                ent_wr.en                = 1'b1;
                ent_wr.data.writable     = 1'b1;
                result_next.frame_number = ent_rd.frame;
            end
            else if (!cnt_rd.any_free)
            begin
                result_next.status = ST_NOFRAME;
            end
            else
            begin
                // move to a fresh frame: release the old one now, claim the new one next
                ent_wr.en                = 1'b1;
                ent_wr.data.writable     = 1'b1;
                ent_wr.data.frame        = cnt_rd.free_frame;
                exec_cnt_wr.en           = 1'b1;
                exec_cnt_wr.frame        = ent_rd.frame;
                exec_cnt_wr.count        = cnt - 8'd1;
                copy_next                = 1'b1;
                result_next.frame_number = cnt_rd.free_frame;
            end
        end
        else
        begin
            ent_wr.en                = 1'b1;
            ent_wr.data.writable     = 1'b0;
            exec_cnt_wr.en           = 1'b1;
            exec_cnt_wr.frame        = ent_rd.frame;
            exec_cnt_wr.count        = (cnt == COUNT_MAX) ? cnt : cnt + 8'd1;
            result_next.frame_number = ent_rd.frame;
        end
        if (state_reg != S_EXEC)
        begin
            ent_wr.en = 1'b0;
        end
    end

    // count port: decode write in exec, fresh frame claim in copy
    always_comb
    begin
        cnt_wr = '0;
        unique case (state_reg)
            S_EXEC:
            begin
                cnt_wr = exec_cnt_wr;
            end
            S_COPY:
            begin
                cnt_wr.en    = 1'b1;
                cnt_wr.frame = cnt_rd.free_frame;
                cnt_wr.count = 8'd1;
            end
            default:
            begin
                cnt_wr = '0;
            end
        endcase
    end

    // sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cmd_reg      <= '0;
            in_range_reg <= 1'b0;
            done_reg     <= 1'b0;
            result_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg      <= cmd;
                        in_range_reg <= ({5'd0, cmd.page_number} < PAGE_LIMIT);
                        state_reg    <= S_COUNT;
                    end
                end
                S_COUNT:
                begin
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    result_reg <= result_next;
                    if (copy_next)
                    begin
                        state_reg <= S_COPY;
                    end
                    else
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                S_COPY:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== sv/cpfa_entry_mem.sv =====
// ----------------------------------------------------------------------------
// cpfa_entry_mem: page entry store
// Synchronous memory of page entries with registered read. Valid
// bits sit in flip-flops cleared by reset; an invalid entry reads as zero.
// ----------------------------------------------------------------------------
module cpfa_entry_mem
    import cpfa_pkg::*;
#(
    parameter int PAGE_DEPTH = 256
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      rd_en,
    input  logic [7:0] rd_addr,
    output entry_t    rd_data,
    input  entry_wr_t wr
);

    localparam int AW = $clog2(PAGE_DEPTH);

    entry_t                  mem [PAGE_DEPTH];
    logic [PAGE_DEPTH-1:0]   valid_reg;
    logic                    rd_valid_reg;
    entry_t                  rd_data_reg;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr[AW-1:0]];
            end
            if (wr.en)
            begin
                valid_reg[wr.addr[AW-1:0]] <= wr.data.valid;
            end
        end
    end

    // entry array, registered read
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr[AW-1:0]] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr[AW-1:0]];
        end
    end

    // an entry never written or freed reads as all zero
    always_comb
    begin
        rd_data = '0;
        if (rd_valid_reg)
        begin
            rd_data       = rd_data_reg;
            rd_data.valid = 1'b1;
        end
    end

endmodule

// ===== sv/cpfa_count_mem.sv =====
// ----------------------------------------------------------------------------
// cpfa_count_mem: frame reference counts
// Count memory with registered read plus a free flag per frame in
// flip-flops; the smallest free frame is searched and registered on a read.
// ----------------------------------------------------------------------------
module cpfa_count_mem
    import cpfa_pkg::*;
#(
    parameter int FRAMES_USED = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rd_en,
    input  logic [3:0] rd_frame,
    output cnt_rd_t    rd_data,
    input  cnt_wr_t    wr
);

    localparam int FW = (FRAMES_USED > 1) ? $clog2(FRAMES_USED) : 1;

    logic [7:0]             mem [FRAMES_USED];
    logic [FRAMES_USED-1:0] free_reg;
    logic                   rd_free_reg;
    logic [7:0]             rd_count_reg;
    logic                   any_free_reg;
    logic [3:0]             free_frame_reg;
    logic                   any_free;
    logic [3:0]             free_frame;

    // smallest free frame
    always_comb
    begin
        any_free   = 1'b0;
        free_frame = '0;
        for (int i = FRAMES_USED - 1; i >= 0; i--)
        begin
            if (free_reg[i])
            begin
                any_free   = 1'b1;
                free_frame = 4'(i);
            end
        end
    end

    // free flags and registered search result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg       <= '1;
            rd_free_reg    <= 1'b1;
            any_free_reg   <= 1'b0;
            free_frame_reg <= '0;
        end
        else
        begin
            if (rd_en)
            begin
                rd_free_reg    <= free_reg[rd_frame[FW-1:0]];
                any_free_reg   <= any_free;
                free_frame_reg <= free_frame;
            end
            if (wr.en)
            begin
                free_reg[wr.frame[FW-1:0]] <= (wr.count == 8'd0);
            end
        end
    end

    // count array, registered read
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.frame[FW-1:0]] <= wr.count;
        end
        if (rd_en)
        begin
            rd_count_reg <= mem[rd_frame[FW-1:0]];
        end
    end

    // a free frame reads as count zero
    assign rd_data.count      = rd_free_reg ? 8'd0 : rd_count_reg;
    assign rd_data.any_free   = any_free_reg;
    assign rd_data.free_frame = free_frame_reg;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for cow_page_frame_allocator_core
// Drives command words through the start/busy handshake and keeps its own
// page table and frame counts to work out each reply. Directed tests cover
// every opcode, the rights codes, each status but no-frame and count saturation; a
// random phase then mixes alloc/free/fault/share sequences on a small
// window of pages with stray words and random gaps.
// ----------------------------------------------------------------------------
module testbench;
    import cpfa_pkg::*;

    localparam int FRAMES            = 16;
    localparam int ENTRIES_PER_TABLE = 16;
    localparam int PAGES_USED        = ENTRIES_PER_TABLE * ENTRIES_PER_TABLE;
    localparam int FRAMES_USABLE     = (FRAMES < 16) ? FRAMES : 16;
    localparam int CMD_BITS          = $bits(cmd_t);
    localparam int WINDOW_PAGES      = 20;
    localparam int STRAND_LIMIT      = 9;
    localparam int RANDOM_WORDS      = 1320;
    localparam int DRAIN_CYCLES      = 8;
    localparam int CYCLE_LIMIT       = 1000000;

    // rights codes that leave the entry flags alone on allocate
    localparam logic [1:0] RIGHTS_NONE = 2'b00;
    localparam logic [1:0] RIGHTS_WO   = 2'b10;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    cmd_t    cmd;
    logic    done;
    result_t result;

    // page table and frame counts as the block should hold them
    logic       pg_valid     [256];
    logic       pg_writable  [256];
    logic       pg_ro_origin [256];
    logic [3:0] pg_frame     [256];
    logic [7:0] frame_refs   [FRAMES];

    result_t page_op_replies [$];
    result_t want;
    int      mismatches;
    int      cycle_count;
    int      burst_left;

    cow_page_frame_allocator_core #(
        .FRAMES            (FRAMES),
        .ENTRIES_PER_TABLE (ENTRIES_PER_TABLE)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("cow_page_frame_allocator_core test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // allocator prediction
    // ------------------------------------------------------------------

    task automatic clear_page_table();
        for (int q = 0; q < 256; q++)
        begin
            pg_valid[q]     = 1'b0;
            pg_writable[q]  = 1'b0;
            pg_ro_origin[q] = 1'b0;
            pg_frame[q]     = '0;
        end
        for (int f = 0; f < FRAMES; f++)
            frame_refs[f] = '0;
    endtask

    function automatic int lowest_free_frame();
        for (int f = 0; f < FRAMES_USABLE; f++)
        begin
            if (frame_refs[f] == 8'd0)
                return f;
        end
        return -1;
    endfunction

    function automatic void bump_count(input int f);
        if (f < FRAMES && frame_refs[f] < COUNT_MAX)
            frame_refs[f]++;
    endfunction

    function automatic void drop_count(input int f);
        if (f < FRAMES && frame_refs[f] > 8'd0)
            frame_refs[f]--;
    endfunction

    // apply one command to the page table, return the reply it gives
    function automatic result_t apply_page_op(input cmd_t word);
        result_t    reply;
        int         p;
        int         pick;
        int         held;
        logic [3:0] cur;
        p                  = int'(word.page_number);
        reply.status       = ST_OK;
        reply.frame_number = '0;
        if (p >= PAGES_USED)
            reply.status = ST_INVALID;
        else if (word.opcode == OP_ALLOC)
        begin
            // frame search first, nothing changes when none is free
            pick = lowest_free_frame();
            if (pick < 0)
                reply.status = ST_NOFRAME;
            else
            begin
                pg_valid[p] = 1'b1;
                if (word.access_rights == RIGHTS_RO)
                begin
                    pg_writable[p]  = 1'b0;
                    pg_ro_origin[p] = 1'b1;
                end
                else if (word.access_rights == RIGHTS_RW)
                begin
                    pg_writable[p]  = 1'b1;
                    pg_ro_origin[p] = 1'b0;
                end
                pg_frame[p] = 4'(pick);
                bump_count(pick);
                reply.frame_number = 4'(pick);
            end
        end
        else if (!pg_valid[p])
            reply.status = ST_INVALID;
        else if (word.opcode == OP_FREE)
        begin
            drop_count(int'(pg_frame[p]));
            pg_valid[p]     = 1'b0;
            pg_writable[p]  = 1'b0;
            pg_ro_origin[p] = 1'b0;
            pg_frame[p]     = '0;
        end
        else if (word.opcode == OP_FAULT)
        begin
            cur  = pg_frame[p];
            held = (int'(cur) < FRAMES) ? int'(frame_refs[cur]) : 0;
            if (pg_writable[p] || !word.access_rights[RIGHT_WRITE])
                reply.status = ST_NOTCOW;
            else if (pg_ro_origin[p])
                reply.status = ST_READONLY;
            else if (held <= 1)
            begin
                // sole user keeps the frame
                pg_writable[p]     = 1'b1;
                reply.frame_number = cur;
            end
            else
            begin
                // shared frame: copy to a fresh one
                pick = lowest_free_frame();
                if (pick < 0)
                    reply.status = ST_NOFRAME;
                else
                begin
                    drop_count(int'(cur));
                    pg_frame[p]    = 4'(pick);
                    pg_writable[p] = 1'b1;
                    bump_count(pick);
                    reply.frame_number = 4'(pick);
                end
            end
        end
        else
        begin
            pg_writable[p] = 1'b0;
            bump_count(int'(pg_frame[p]));
            reply.frame_number = pg_frame[p];
        end
        return reply;
    endfunction

    // frames whose count exceeds the entries that point at them
    function automatic int stranded_frames();
        int users [FRAMES];
        int n;
        n = 0;
        for (int f = 0; f < FRAMES; f++)
            users[f] = 0;
        for (int q = 0; q < 256; q++)
        begin
            if (pg_valid[q] && int'(pg_frame[q]) < FRAMES)
                users[pg_frame[q]]++;
        end
        for (int f = 0; f < FRAMES; f++)
        begin
            if (int'(frame_refs[f]) > users[f])
                n++;
        end
        return n;
    endfunction

    function automatic logic room_to_strand();
        return stranded_frames() < STRAND_LIMIT;
    endfunction

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    // idle cycles after a word: mostly none or short, a few long, some bursts
    function automatic int pick_gap();
        int roll;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 5)
        begin
            burst_left = $urandom_range(5, 30);
            return 0;
        end
        if (roll < 50)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // present one command word at a falling edge and hold it until taken
    task automatic issue_op(input logic [1:0] op, input logic [7:0] page,
                            input logic [1:0] rights);
        cmd_t word;
        int   gap;
        word.opcode        = op;
        word.page_number   = page;
        word.access_rights = rights;
        start <= 1'b1;
        cmd   <= word;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        page_op_replies.push_back(apply_page_op(word));
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            cmd   <= CMD_BITS'($urandom);
            repeat (gap) @(negedge clk);
        end
    endtask

    function automatic logic [7:0] window_page();
        return 8'(37 * $urandom_range(0, WINDOW_PAGES - 1) + 3);
    endfunction

    // allocate with each rights code on pages 0, 255, 128 and 1
    task automatic test_alloc_rights();
        issue_op(OP_ALLOC, 8'd0,   RIGHTS_RW);
        issue_op(OP_ALLOC, 8'd255, RIGHTS_RO);
        issue_op(OP_ALLOC, 8'd128, RIGHTS_NONE);
        issue_op(OP_ALLOC, 8'd1,   RIGHTS_WO);
    endtask

    // fault ordering: invalid, writable, no write bit, read-only, in place
    task automatic test_fault_checks();
        issue_op(OP_FAULT, 8'd9,   RIGHTS_RW);
        issue_op(OP_FAULT, 8'd0,   RIGHTS_RW);
        issue_op(OP_FAULT, 8'd128, RIGHTS_RO);
        issue_op(OP_FAULT, 8'd255, RIGHTS_RW);
        issue_op(OP_FAULT, 8'd128, RIGHTS_WO);
    endtask

    // share then a write fault that copies to a fresh frame
    task automatic test_share_copy();
        issue_op(OP_SHARE, 8'd1, RIGHTS_NONE);
        issue_op(OP_FAULT, 8'd1, RIGHTS_RW);
        issue_op(OP_SHARE, 8'd9, RIGHTS_RW);
    endtask

    // allocate over a valid entry keeps the flags for rights with no read bit
    task automatic test_alloc_remap();
        issue_op(OP_ALLOC, 8'd128, RIGHTS_NONE);
        issue_op(OP_FAULT, 8'd128, RIGHTS_RW);
    endtask

    // free of invalid and valid entries, and a double free
    task automatic test_free_paths();
        issue_op(OP_FREE, 8'd9,   RIGHTS_NONE);
        issue_op(OP_FREE, 8'd0,   RIGHTS_RW);
        issue_op(OP_FREE, 8'd255, RIGHTS_RO);
        issue_op(OP_FREE, 8'd128, RIGHTS_WO);
        issue_op(OP_FREE, 8'd1,   RIGHTS_NONE);
        issue_op(OP_FREE, 8'd0,   RIGHTS_RW);
    endtask

    // share until the count pins at its maximum, then copy and free
    task automatic test_count_saturation();
        issue_op(OP_ALLOC, 8'd7, RIGHTS_RW);
        for (int k = 0; k < 258; k++)
            issue_op(OP_SHARE, 8'd7, 2'($urandom_range(0, 3)));
        issue_op(OP_FAULT, 8'd7, RIGHTS_WO);
        issue_op(OP_FREE,  8'd7, RIGHTS_NONE);
    endtask

    // mostly well-formed sequences on a page window, some stray words
    task automatic test_random_ops(input int count);
        logic [1:0] op;
        logic [7:0] page;
        logic [1:0] rights;
        int         roll;
        for (int i = 0; i < count; i++)
        begin
            roll   = $urandom_range(0, 99);
            rights = 2'($urandom_range(0, 3));
            if (roll < 12)
            begin
                // stray word, kept from stranding too many frames
                op   = 2'($urandom_range(0, 3));
                page = 8'($urandom);
                if (op == OP_ALLOC)
                    page = window_page();
                if ((op == OP_SHARE || op == OP_ALLOC) && pg_valid[page]
                    && !room_to_strand())
                    op = OP_FAULT;
            end
            else
            begin
                page = window_page();
                roll = $urandom_range(0, 99);
                if (!pg_valid[page])
                    op = (roll < 90) ? OP_ALLOC : 2'($urandom_range(1, 3));
                else if (roll < 35)
                    op = OP_FREE;
                else if (roll < 75)
                begin
                    op = OP_FAULT;
                    if ($urandom_range(0, 4) != 0)
                        rights[RIGHT_WRITE] = 1'b1;
                end
                else if (roll < 90)
                    op = room_to_strand() ? OP_SHARE : OP_FAULT;
                else
                    op = room_to_strand() ? OP_ALLOC : OP_FREE;
            end
            issue_op(op, page, rights);
        end
    endtask

    // ------------------------------------------------------------------
    // reply checking
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (page_op_replies.size() == 0)
            begin
                $error("result word with no command outstanding: status %0d frame %0d",
                       result.status, result.frame_number);
                mismatches++;
            end
            else
            begin
                want = page_op_replies.pop_front();
                if (result.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, result.status);
                    mismatches++;
                end
                if (result.frame_number !== want.frame_number)
                begin
                    $error("frame_number: expected %0d, got %0d",
                           want.frame_number, result.frame_number);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------

    initial
    begin
        mismatches  = 0;
        cycle_count = 0;
        burst_left  = 0;
        clear_page_table();
        rst_n <= 1'b0;
        start <= 1'b0;
        cmd   <= '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_alloc_rights();
        test_fault_checks();
        test_share_copy();
        test_alloc_remap();
        test_free_paths();
        test_count_saturation();
        test_random_ops(RANDOM_WORDS);

        start <= 1'b0;
        wait (page_op_replies.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("cow_page_frame_allocator_core test passed");
        else
            $display("cow_page_frame_allocator_core test failed");
        $finish;
    end

endmodule
